// ----- hdl/crsf_pkg.sv -----
package crsf_pkg;

  localparam int unsigned ChannelCount   = 16;
  localparam int unsigned RcPayloadBytes = 22;
  localparam int unsigned ChanW          = 11;
  localparam int unsigned ChIdxW         = $clog2(ChannelCount);
  localparam int unsigned AccW           = 18;
  localparam int unsigned BitCntW        = 5;
  localparam logic [7:0]  CrcPoly        = 8'hD5;
  localparam logic [7:0]  MinLen         = 8'd4;

  typedef enum logic [7:0] {
    REG_SYNC    = 8'd0,
    REG_RC_TYPE = 8'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_FRAME_OK = 3'd1,
    EV_CRC_ERR  = 3'd2,
    EV_LEN_ERR  = 3'd3,
    EV_CHANNEL  = 3'd4
  } event_e;

  typedef enum logic [4:0] {
    PH_SYNC    = 5'b00001,
    PH_LEN     = 5'b00010,
    PH_TYPE    = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CRC     = 5'b10000
  } phase_e;

  typedef struct packed {
    logic              valid;
    logic [ChIdxW-1:0] index;
    logic [ChanW-1:0]  value;
    logic              last;
  } chan_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- hdl/crsf_frame_receiver.sv -----
// Each accepted byte's result is loaded into the output register as the byte is taken.
// Throughput: one byte per cycle while the output slot is free and no channel run is
// busy; the CRC byte of a good RC frame yields 16 channel transactions, built from
// 22 frame store reads, during which no byte is taken.
// Reset: parser, counters and config registers cleared to defaults; the frame store
// is not cleared, it is only read at entries written in the current frame.
module crsf_frame_receiver #(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_code_o,
  output logic [3:0]  channel_index_o,
  output logic [10:0] channel_value_o,
  output logic        last_of_run_o,
  output logic [31:0] bytes_seen_o,
  output logic [31:0] good_frames_o,
  output logic [31:0] length_errors_o,
  output logic [31:0] crc_errors_o
);
  import crsf_pkg::*;

  localparam int unsigned PosW   = $clog2(MAX_FRAME_BYTES);
  localparam logic [8:0]  MaxLen = 9'(MAX_FRAME_BYTES - 2);

  logic [7:0]        sync_q, rc_type_q;
  phase_e            phase_q, phase_d;
  logic [PosW-1:0]   plen_q, plen_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [7:0]        crc_q, crc_d;
  logic [7:0]        type_q, type_d;
  logic [31:0]       byte_cnt_q, ok_cnt_q, len_err_q, crc_err_q;
  logic              out_valid_q, out_valid_d;
  event_e            ev_q, ev_d;
  event_e            byte_ev;
  logic [ChIdxW-1:0] idx_q, idx_d;
  logic [ChanW-1:0]  val_q, val_d;
  logic              last_q, last_d;

  logic              slot_free, in_fire, run_busy, start_run;
  logic              mem_we;
  logic [PosW-1:0]   mem_waddr, mem_raddr;
  logic [7:0]        mem_rdata;
  logic              len_bad, crc_good, is_rc;
  chan_t             chan;

  assign cfg_ready_o = 1'b1;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = slot_free && !run_busy;
  assign in_fire     = in_valid_i && in_ready_o;

  assign len_bad  = (rx_byte_i < MinLen) || ({1'b0, rx_byte_i} > MaxLen);
  assign crc_good = (rx_byte_i == crc_q);
  assign is_rc    = (type_q == rc_type_q) && (plen_q >= PosW'(RcPayloadBytes));

  always_comb begin
    phase_d   = phase_q;
    plen_d    = plen_q;
    pos_d     = pos_q;
    crc_d     = crc_q;
    type_d    = type_q;
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    byte_ev   = EV_NONE;
    start_run = 1'b0;
    unique case (phase_q)
      PH_LEN: begin
        if (len_bad) begin
          phase_d = PH_SYNC;
          byte_ev = EV_LEN_ERR;
        end else begin
          plen_d  = PosW'(rx_byte_i - 8'd2);
          pos_d   = '0;
          phase_d = PH_TYPE;
        end
      end
      PH_TYPE: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        type_d    = rx_byte_i;
        crc_d     = crc8_update(8'd0, rx_byte_i);
        pos_d     = PosW'(1);
        phase_d   = (plen_q != '0) ? PH_PAYLOAD : PH_CRC;
      end
      PH_PAYLOAD: begin
        mem_we = 1'b1;
        crc_d  = crc8_update(crc_q, rx_byte_i);
        pos_d  = pos_q + 1'b1;
        if (pos_q >= plen_q) begin
          phase_d = PH_CRC;
        end
      end
      PH_CRC: begin
        phase_d = PH_SYNC;
        if (!crc_good) begin
          byte_ev = EV_CRC_ERR;
        end else if (is_rc) begin
          start_run = 1'b1;
        end else begin
          byte_ev = EV_FRAME_OK;
        end
      end
      default: begin
        phase_d = (rx_byte_i == sync_q) ? PH_LEN : PH_SYNC;
      end
    endcase
    if (!in_fire) begin
      mem_we    = 1'b0;
      start_run = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    ev_d        = ev_q;
    idx_d       = idx_q;
    val_d       = val_q;
    last_d      = last_q;
    if (in_fire) begin
      out_valid_d = !start_run;
      ev_d        = byte_ev;
      idx_d       = '0;
      val_d       = '0;
      last_d      = 1'b1;
    end else if (chan.valid) begin
      out_valid_d = 1'b1;
      ev_d        = EV_CHANNEL;
      idx_d       = chan.index;
      val_d       = chan.value;
      last_d      = chan.last;
    end else begin
      if (out_ready_i) begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q      <= 8'd200;
      rc_type_q   <= 8'd22;
      phase_q     <= PH_SYNC;
      plen_q      <= '0;
      pos_q       <= '0;
      crc_q       <= '0;
      byte_cnt_q  <= '0;
      ok_cnt_q    <= '0;
      len_err_q   <= '0;
      crc_err_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_SYNC:    sync_q    <= cfg_data_i;
          REG_RC_TYPE: rc_type_q <= cfg_data_i;
          default: ;
        endcase
      end
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        phase_q    <= phase_d;
        plen_q     <= plen_d;
        pos_q      <= pos_d;
        crc_q      <= crc_d;
        byte_cnt_q <= byte_cnt_q + 32'd1;
        if (byte_ev == EV_LEN_ERR) begin
          len_err_q <= len_err_q + 32'd1;
        end
        if (byte_ev == EV_CRC_ERR) begin
          crc_err_q <= crc_err_q + 32'd1;
        end
        if (byte_ev == EV_FRAME_OK || start_run) begin
          ok_cnt_q <= ok_cnt_q + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      type_q <= type_d;
    end
    ev_q   <= ev_d;
    idx_q  <= idx_d;
    val_q  <= val_d;
    last_q <= last_d;
  end

  crsf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FRAME_BYTES)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (rx_byte_i),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  crsf_chan_unpack #(
    .ADDR_W (PosW)
  ) u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_run),
    .slot_free_i (slot_free),
    .rdata_i     (mem_rdata),
    .raddr_o     (mem_raddr),
    .busy_o      (run_busy),
    .chan_o      (chan)
  );

  assign out_valid_o     = out_valid_q;
  assign event_code_o    = ev_q;
  assign channel_index_o = idx_q;
  assign channel_value_o = val_q;
  assign last_of_run_o   = last_q;
  assign bytes_seen_o    = byte_cnt_q;
  assign good_frames_o   = ok_cnt_q;
  assign length_errors_o = len_err_q;
  assign crc_errors_o    = crc_err_q;

endmodule

// ----- hdl/crsf_ram.sv -----
module crsf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/crsf_chan_unpack.sv -----
module crsf_chan_unpack #(
  parameter int unsigned ADDR_W = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                slot_free_i,
  input  logic [7:0]          rdata_i,
  output logic [ADDR_W-1:0]   raddr_o,
  output logic                busy_o,
  output crsf_pkg::chan_t     chan_o
);
  import crsf_pkg::*;

  logic                active_q, active_d;
  logic                rd_pend_q, rd_pend_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [AccW-1:0]     acc_q, acc_d;
  logic [BitCntW-1:0]  nbits_q, nbits_d;
  logic [ChIdxW-1:0]   idx_q, idx_d;
  logic                emit;

  assign emit    = active_q && !rd_pend_q && (nbits_q >= BitCntW'(ChanW)) && slot_free_i;
  assign raddr_o = addr_q;
  assign busy_o  = active_q;

  assign chan_o.valid = emit;
  assign chan_o.index = idx_q;
  assign chan_o.value = acc_q[ChanW-1:0];
  assign chan_o.last  = (idx_q == ChIdxW'(ChannelCount - 1));

  always_comb begin
    active_d  = active_q;
    rd_pend_d = 1'b0;
    addr_d    = addr_q;
    acc_d     = acc_q;
    nbits_d   = nbits_q;
    idx_d     = idx_q;
    if (start_i) begin
      active_d = 1'b1;
      addr_d   = ADDR_W'(1);
      acc_d    = '0;
      nbits_d  = '0;
      idx_d    = '0;
    end else if (active_q) begin
      if (rd_pend_q) begin
        acc_d   = acc_q | (AccW'(rdata_i) << nbits_q);
        nbits_d = nbits_q + BitCntW'(8);
      end else if (nbits_q >= BitCntW'(ChanW)) begin
        if (emit) begin
          acc_d   = acc_q >> ChanW;
          nbits_d = nbits_q - BitCntW'(ChanW);
          idx_d   = idx_q + 1'b1;
          if (chan_o.last) begin
            active_d = 1'b0;
          end
        end
      end else begin
        rd_pend_d = 1'b1;
        addr_d    = addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      rd_pend_q <= 1'b0;
      addr_q    <= '0;
      nbits_q   <= '0;
      idx_q     <= '0;
    end else begin
      active_q  <= active_d;
      rd_pend_q <= rd_pend_d;
      addr_q    <= addr_d;
      nbits_q   <= nbits_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

// ----- dv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crsf_pkg::*;

  localparam int FrameMax     = 64;
  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 80;
  localparam int LongHold     = 250;
  localparam int PrintLimit   = 40;

  typedef struct packed {
    event_e      ev;
    logic [3:0]  ch_idx;
    logic [10:0] ch_val;
    logic        last;
    logic [31:0] n_bytes;
    logic [31:0] n_good;
    logic [31:0] n_len_err;
    logic [31:0] n_crc_err;
  } rx_event_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  event_code_o;
  logic [3:0]  channel_index_o;
  logic [10:0] channel_value_o;
  logic        last_of_run_o;
  logic [31:0] bytes_seen_o;
  logic [31:0] good_frames_o;
  logic [31:0] length_errors_o;
  logic [31:0] crc_errors_o;

  crsf_frame_receiver #(
    .MAX_FRAME_BYTES(FrameMax)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_code_o    (event_code_o),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .last_of_run_o   (last_of_run_o),
    .bytes_seen_o    (bytes_seen_o),
    .good_frames_o   (good_frames_o),
    .length_errors_o (length_errors_o),
    .crc_errors_o    (crc_errors_o)
  );

  // parser mirror
  logic [7:0]  sync_cfg;
  logic [7:0]  rc_type_cfg;
  phase_e      rx_phase;
  int          frame_len;
  int          frame_pos;
  logic [7:0]  crc_acc;
  logic [7:0]  frame_buf [FrameMax];
  logic [31:0] byte_cnt;
  logic [31:0] good_cnt;
  logic [31:0] len_err_cnt;
  logic [31:0] crc_err_cnt;

  logic [7:0] rx_stream[$];
  rx_event_t  rx_events_due[$];
  rx_event_t  due_head;
  int         mismatch_cnt = 0;
  int         checked_cnt  = 0;
  int         cycle_cnt    = 0;

  int         burst_left = 0;
  int         gap_left   = 0;

  logic       hold_req  = 1'b0;
  bit         hold_done = 0;
  int         hold_left = 0;
  int         stall_mode = 0;
  int         mode_left  = 0;
  logic [7:0] ready_pattern = 8'hFF;
  logic [2:0] pat_pos = '0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [7:0] crc_d5(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CrcPoly) : {r[6:0], 1'b0};
    return r;
  endfunction

  task automatic push_event(input event_e ev, input logic [3:0] idx, input logic [10:0] val,
                            input logic last);
    rx_event_t e;
    e.ev        = ev;
    e.ch_idx    = idx;
    e.ch_val    = val;
    e.last      = last;
    e.n_bytes   = byte_cnt;
    e.n_good    = good_cnt;
    e.n_len_err = len_err_cnt;
    e.n_crc_err = crc_err_cnt;
    rx_events_due.push_back(e);
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    logic [8*RcPayloadBytes-1:0] rc_bits;
    byte_cnt++;
    case (rx_phase)
      PH_LEN: begin
        if (b < MinLen || int'(b) > FrameMax - 2) begin
          len_err_cnt++;
          rx_phase = PH_SYNC;
          push_event(EV_LEN_ERR, '0, '0, 1'b1);
          return;
        end
        frame_len = int'(b) - 2;
        frame_pos = 0;
        rx_phase  = PH_TYPE;
      end
      PH_TYPE: begin
        frame_buf[0] = b;
        crc_acc      = crc_d5(8'h00, b);
        frame_pos    = 1;
        rx_phase     = (frame_len > 0) ? PH_PAYLOAD : PH_CRC;
      end
      PH_PAYLOAD: begin
        if (frame_pos < FrameMax) frame_buf[frame_pos] = b;
        crc_acc = crc_d5(crc_acc, b);
        frame_pos++;
        if (frame_pos > frame_len || frame_pos >= FrameMax) rx_phase = PH_CRC;
      end
      PH_CRC: begin
        rx_phase = PH_SYNC;
        if (b != crc_acc) begin
          crc_err_cnt++;
          push_event(EV_CRC_ERR, '0, '0, 1'b1);
          return;
        end
        good_cnt++;
        if (frame_buf[0] == rc_type_cfg && frame_len >= RcPayloadBytes) begin
          for (int i = 0; i < RcPayloadBytes; i++) rc_bits[8*i +: 8] = frame_buf[i+1];
          for (int k = 0; k < ChannelCount; k++) begin
            push_event(EV_CHANNEL, k[3:0], rc_bits[ChanW*k +: ChanW], k == ChannelCount - 1);
          end
          return;
        end
        push_event(EV_FRAME_OK, '0, '0, 1'b1);
        return;
      end
      default: begin
        rx_phase = (b == sync_cfg) ? PH_LEN : PH_SYNC;
      end
    endcase
    push_event(EV_NONE, '0, '0, 1'b1);
  endtask

  // byte source: bursts with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) parse_rx_byte(rx_byte_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (rx_stream.size() > 0) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= rx_stream.pop_front();
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result sink: changing stall modes plus one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_left = LongHold;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode    = $urandom_range(0, 3);
          mode_left     = $urandom_range(16, 96);
          ready_pattern = 8'($urandom_range(1, 255));
        end else begin
          mode_left--;
        end
        pat_pos = pat_pos + 3'd1;
        case (stall_mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ready_pattern[pat_pos];
        endcase
      end
    end
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_cnt < PrintLimit)
      $display("[%0t] result %0d: %s got %0d, expected %0d", $realtime, checked_cnt, field,
               got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rx_events_due.size() == 0) begin
        report_mismatch("unexpected transaction, event", 32'(event_code_o), 32'(EV_NONE));
      end else begin
        due_head = rx_events_due.pop_front();
        if (event_code_o != due_head.ev)
          report_mismatch("event_code", 32'(event_code_o), 32'(due_head.ev));
        if (channel_index_o != due_head.ch_idx)
          report_mismatch("channel_index", 32'(channel_index_o), 32'(due_head.ch_idx));
        if (channel_value_o != due_head.ch_val)
          report_mismatch("channel_value", 32'(channel_value_o), 32'(due_head.ch_val));
        if (last_of_run_o != due_head.last)
          report_mismatch("last_of_run", 32'(last_of_run_o), 32'(due_head.last));
        if (bytes_seen_o != due_head.n_bytes)
          report_mismatch("bytes_seen", bytes_seen_o, due_head.n_bytes);
        if (good_frames_o != due_head.n_good)
          report_mismatch("good_frames", good_frames_o, due_head.n_good);
        if (length_errors_o != due_head.n_len_err)
          report_mismatch("length_errors", length_errors_o, due_head.n_len_err);
        if (crc_errors_o != due_head.n_crc_err)
          report_mismatch("crc_errors", crc_errors_o, due_head.n_crc_err);
      end
      checked_cnt++;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_cfg(input cfg_reg_e idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_SYNC:    sync_cfg    = val;
      REG_RC_TYPE: rc_type_cfg = val;
      default: ;
    endcase
  endtask

  // fill: 0 random (some bytes equal to sync), 1 all zero, 2 all ones
  task automatic queue_frame(input logic [7:0] ftype, input int plen, input bit bad_crc,
                             input int fill);
    logic [7:0] crc;
    logic [7:0] d;
    rx_stream.push_back(sync_cfg);
    rx_stream.push_back(8'(plen + 2));
    rx_stream.push_back(ftype);
    crc = crc_d5(8'h00, ftype);
    for (int i = 0; i < plen; i++) begin
      case (fill)
        1:       d = 8'h00;
        2:       d = 8'hFF;
        default: d = ($urandom_range(0, 7) == 0) ? sync_cfg : 8'($urandom);
      endcase
      rx_stream.push_back(d);
      crc = crc_d5(crc, d);
    end
    if (bad_crc) crc = crc ^ 8'($urandom_range(1, 255));
    rx_stream.push_back(crc);
  endtask

  task automatic queue_traffic(input int n_bytes);
    int goal;
    int sel;
    int plen;
    logic [7:0] ftype;
    goal = rx_stream.size() + n_bytes;
    while (rx_stream.size() < goal) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        plen = ($urandom_range(0, 5) == 0) ? $urandom_range(22, 60) : $urandom_range(22, 24);
        queue_frame(rc_type_cfg, plen, $urandom_range(0, 6) == 0, 0);
      end else if (sel < 55) begin
        ftype = 8'($urandom);
        queue_frame(ftype, $urandom_range(2, 12), $urandom_range(0, 5) == 0, 0);
      end else if (sel < 65) begin
        queue_frame(rc_type_cfg, $urandom_range(2, 21), $urandom_range(0, 5) == 0, 0);
      end else if (sel < 80) begin
        repeat ($urandom_range(1, 4)) rx_stream.push_back(8'($urandom));
      end else if (sel < 90) begin
        rx_stream.push_back(sync_cfg);
        rx_stream.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                                 : 8'($urandom_range(FrameMax - 1, 255)));
      end else begin
        plen = $urandom_range(2, 20);
        rx_stream.push_back(sync_cfg);
        rx_stream.push_back(8'(plen + 2));
        repeat ($urandom_range(1, plen)) rx_stream.push_back(8'($urandom));
      end
    end
  endtask

  task automatic drain;
    while (rx_stream.size() != 0 || in_valid_i) @(posedge clk_i);
    while (rx_events_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    sync_cfg    = 8'd200;
    rc_type_cfg = 8'd22;
    rx_phase    = PH_SYNC;
    frame_len   = 0;
    frame_pos   = 0;
    crc_acc     = '0;
    byte_cnt    = '0;
    good_cnt    = '0;
    len_err_cnt = '0;
    crc_err_cnt = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_cfg(REG_SYNC, 8'd200);
    write_cfg(REG_RC_TYPE, 8'd22);

    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(sync_cfg);
    rx_stream.push_back(8'd3);
    rx_stream.push_back(sync_cfg);
    rx_stream.push_back(8'(FrameMax - 1));
    rx_stream.push_back(sync_cfg);
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(sync_cfg);
    rx_stream.push_back(8'h00);
    queue_frame(8'h10, 2, 0, 0);
    queue_frame(8'h10, 2, 1, 0);
    queue_frame(rc_type_cfg, 2, 0, 0);
    drain();

    queue_frame(rc_type_cfg, RcPayloadBytes, 0, 1);
    queue_frame(rc_type_cfg, RcPayloadBytes, 0, 2);
    queue_frame(rc_type_cfg, FrameMax - 4, 0, 0);
    queue_traffic(40);
    hold_req <= 1'b1;
    drain();

    write_cfg(REG_SYNC, 8'h00);
    write_cfg(REG_RC_TYPE, 8'hFF);
    queue_traffic(40);
    drain();

    write_cfg(REG_SYNC, 8'hFF);
    write_cfg(REG_RC_TYPE, 8'h00);
    queue_traffic(40);
    drain();

    // sync equal to a legal length: sync, sync is a frame start plus length
    write_cfg(REG_SYNC, 8'd24);
    write_cfg(REG_RC_TYPE, 8'($urandom));
    queue_frame(rc_type_cfg, RcPayloadBytes, 0, 0);
    queue_traffic(30);
    drain();

    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
